[rtl/plst_pkg.sv]
// Shared constants, codes and control types of the palette split table.
package plst_pkg;

  localparam int MAX_LINES_DEF = 512;
  localparam int COLOURS_DEF   = 16;

  localparam int OP_W     = 2;
  localparam int LINE_W   = 9;
  localparam int CIDX_W   = 4;
  localparam int COLOUR_W = 16;
  localparam int SLOT_W   = 9;
  localparam int ACTIVE_W = 10;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(200);

  localparam logic [OP_W-1:0] OP_RESET = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic rd;
    logic fill;
  } map_cmd_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } pal_cmd_t;

endpackage

[rtl/plst_if.sv]
// Handshake channels of the palette split table: request, result and register write.
interface plst_in_if;
  logic                          valid;
  logic                          ready;
  logic [plst_pkg::OP_W-1:0]     operation;
  logic [plst_pkg::LINE_W-1:0]   line;
  logic [plst_pkg::CIDX_W-1:0]   colour_index;
  logic [plst_pkg::COLOUR_W-1:0] colour_in;

  modport source (output valid, operation, line, colour_index, colour_in, input ready);
  modport sink   (input valid, operation, line, colour_index, colour_in, output ready);
endinterface

interface plst_out_if;
  logic                          valid;
  logic                          ready;
  logic [plst_pkg::COLOUR_W-1:0] colour_out;
  logic [plst_pkg::SLOT_W-1:0]   slot;
  logic                          split_made;
  logic                          status;

  modport source (output valid, colour_out, slot, split_made, status, input ready);
  modport sink   (input valid, colour_out, slot, split_made, status, output ready);
endinterface

interface plst_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [plst_pkg::ACTIVE_W-1:0] active_lines;

  modport source (output valid, active_lines, input ready);
  modport sink   (input valid, active_lines, output ready);
endinterface

[rtl/plst_map.sv]
// Line-to-slot map memory with a range fill engine and a clearing pass after reset.
module plst_map #(
  parameter int MAX_LINES = plst_pkg::MAX_LINES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  plst_pkg::map_cmd_t                   cmd,
  input  logic [$clog2(MAX_LINES)-1:0]         addr,
  input  logic [$clog2(MAX_LINES+1)-1:0]       hi,
  input  logic [$clog2(MAX_LINES)-1:0]         wdata,
  output logic [$clog2(MAX_LINES)-1:0]         rdata,
  output logic                                 busy
);

  localparam int SW  = $clog2(MAX_LINES);
  localparam int LCW = $clog2(MAX_LINES+1);

  logic [SW-1:0]  mem [MAX_LINES];
  logic [SW-1:0]  rdata_r;
  logic [LCW-1:0] ptr_r;
  logic [LCW-1:0] hi_r;
  logic [SW-1:0]  val_r;
  logic           busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      ptr_r  <= '0;
      hi_r   <= LCW'(MAX_LINES);
      val_r  <= '0;
    end else if (busy_r) begin
      ptr_r <= ptr_r + LCW'(1);
      if (ptr_r + LCW'(1) == hi_r) begin
        busy_r <= 1'b0;
      end
    end else if (cmd.fill && (LCW'(addr) < hi)) begin
      busy_r <= 1'b1;
      ptr_r  <= LCW'(addr);
      hi_r   <= hi;
      val_r  <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[ptr_r[SW-1:0]] <= val_r;
    end
    if (cmd.rd) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = busy_r;

endmodule

[rtl/plst_pal.sv]
// Palette store memory, one read and one write port, slot 0 entries read as zero until written.
module plst_pal #(
  parameter int MAX_LINES           = plst_pkg::MAX_LINES_DEF,
  parameter int COLOURS_PER_PALETTE = plst_pkg::COLOURS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  plst_pkg::pal_cmd_t                     cmd,
  input  logic [$clog2(MAX_LINES)-1:0]           rd_slot,
  input  logic [$clog2(COLOURS_PER_PALETTE)-1:0] rd_idx,
  input  logic [$clog2(MAX_LINES)-1:0]           wr_slot,
  input  logic [$clog2(COLOURS_PER_PALETTE)-1:0] wr_idx,
  input  logic [plst_pkg::COLOUR_W-1:0]          wdata,
  output logic [plst_pkg::COLOUR_W-1:0]          rdata
);

  localparam int DEPTH = MAX_LINES * COLOURS_PER_PALETTE;
  localparam int AW    = $clog2(DEPTH);

  logic [plst_pkg::COLOUR_W-1:0] mem [DEPTH];
  logic [plst_pkg::COLOUR_W-1:0] q_r;
  logic [COLOURS_PER_PALETTE-1:0] slot0_vld_r;
  logic                           rd_zero_r;
  logic [AW-1:0]                  rd_addr;
  logic [AW-1:0]                  wr_addr;

  assign rd_addr = AW'(rd_slot) * AW'(COLOURS_PER_PALETTE) + AW'(rd_idx);
  assign wr_addr = AW'(wr_slot) * AW'(COLOURS_PER_PALETTE) + AW'(wr_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot0_vld_r <= '0;
      rd_zero_r   <= 1'b0;
    end else begin
      if (cmd.wr && (wr_slot == '0)) begin
        slot0_vld_r[wr_idx] <= 1'b1;
      end
      if (cmd.rd) begin
        rd_zero_r <= (rd_slot == '0) && !slot0_vld_r[rd_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd.rd) begin
      q_r <= mem[rd_addr];
    end
  end

  assign rdata = rd_zero_r ? '0 : q_r;

endmodule

[rtl/per_line_palette_split_table.sv]
// Top level of the per-line palette split table: sequencer, slot count and result register.
//
// Channels: in_chan takes an item (operation, line, colour_index, colour_in) when valid and
// ready are high; out_chan returns exactly one result item per request item (colour_out,
// slot, split_made, status); cfg_chan writes active_lines and is always ready, to be used
// only while the block is idle.
// Path from acceptance to the result stage S_FIN: an unused code or a line out of range goes
// there at once; a reset passes S_RST, a write to line 0 S_WR0, a read S_RD_A, S_RD_B and
// S_RD_C, a write to another line S_WA, S_WB and S_WC, and a write that splits then S_CP (copy
// of the palette above, one colour per cycle through the palette memory) and S_SPLIT.
// One item is worked on at a time; the next is accepted the cycle after the result is
// loaded into the output register. The line map is written only by its fill engine: after a
// reset operation it is swept from line 0 up to the line count in use, after a split from the
// written line up to it, one entry a cycle, and no item is accepted while that sweep runs.
// Reset: active_lines returns to 200, the slot count to zero, and the line map is cleared
// in a pass over all MAX_LINES entries during which in_chan is not ready; configuration
// writes are taken during it. Slot 0 of the palette store reads as zero until written.
// A stalled receiver holds the result in the output register; one further item may be
// worked on meanwhile, and its result waits until the register is free.
module per_line_palette_split_table #(
  parameter int MAX_LINES           = plst_pkg::MAX_LINES_DEF,
  parameter int COLOURS_PER_PALETTE = plst_pkg::COLOURS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  plst_in_if.sink         in_chan,
  plst_out_if.source      out_chan,
  plst_cfg_if.sink        cfg_chan
);

  localparam int SW  = $clog2(MAX_LINES);
  localparam int LCW = $clog2(MAX_LINES+1);
  localparam int IW  = $clog2(COLOURS_PER_PALETTE);
  localparam int KW  = $clog2(COLOURS_PER_PALETTE+1);

  typedef enum logic [3:0] {
    S_IDLE, S_RST, S_RD_A, S_RD_B, S_RD_C, S_WR0,
    S_WA, S_WB, S_WC, S_CP, S_SPLIT, S_FIN
  } state_t;

  function automatic logic [IW-1:0] ci_wrap(input logic [plst_pkg::CIDX_W-1:0] v);
    int r;
    r = int'(v);
    for (int i = 0; i < 8; i++) begin
      if (r >= COLOURS_PER_PALETTE) begin
        r = r - COLOURS_PER_PALETTE;
      end
    end
    return IW'(r);
  endfunction

  state_t                          state_r;
  logic [plst_pkg::ACTIVE_W-1:0]   active_r;
  logic [LCW-1:0]                  slots_used_r;
  logic [LCW-1:0]                  lines_r;
  logic [SW-1:0]                   ln_r;
  logic [IW-1:0]                   ci_r;
  logic [plst_pkg::COLOUR_W-1:0]   col_r;
  logic [SW-1:0]                   above_r;
  logic [SW-1:0]                   fresh_r;
  logic [KW-1:0]                   k_r;
  logic [plst_pkg::COLOUR_W-1:0]   res_col_r;
  logic [SW-1:0]                   res_slot_r;
  logic                            res_split_r;
  logic                            res_status_r;
  logic                            out_valid_r;
  logic [plst_pkg::COLOUR_W-1:0]   out_col_r;
  logic [plst_pkg::SLOT_W-1:0]     out_slot_r;
  logic                            out_split_r;
  logic                            out_status_r;

  logic [LCW-1:0]                  lines;
  logic                            in_oor;
  logic                            in_fire;
  logic [LCW-1:0]                  su_fix;
  logic                            room;
  logic                            same_slot;
  logic                            out_load;

  plst_pkg::map_cmd_t              map_cmd;
  logic [SW-1:0]                   map_addr;
  logic [LCW-1:0]                  map_hi;
  logic [SW-1:0]                   map_wdata;
  logic [SW-1:0]                   map_rdata;
  logic                            map_busy;

  plst_pkg::pal_cmd_t              pal_cmd;
  logic [SW-1:0]                   pal_rd_slot;
  logic [IW-1:0]                   pal_rd_idx;
  logic [SW-1:0]                   pal_wr_slot;
  logic [IW-1:0]                   pal_wr_idx;
  logic [plst_pkg::COLOUR_W-1:0]   pal_wdata;
  logic [plst_pkg::COLOUR_W-1:0]   pal_rdata;

  plst_map #(
    .MAX_LINES (MAX_LINES)
  ) u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (map_cmd),
    .addr  (map_addr),
    .hi    (map_hi),
    .wdata (map_wdata),
    .rdata (map_rdata),
    .busy  (map_busy)
  );

  plst_pal #(
    .MAX_LINES           (MAX_LINES),
    .COLOURS_PER_PALETTE (COLOURS_PER_PALETTE)
  ) u_pal (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (pal_cmd),
    .rd_slot (pal_rd_slot),
    .rd_idx  (pal_rd_idx),
    .wr_slot (pal_wr_slot),
    .wr_idx  (pal_wr_idx),
    .wdata   (pal_wdata),
    .rdata   (pal_rdata)
  );

  assign lines     = (32'(active_r) > MAX_LINES) ? LCW'(MAX_LINES) : LCW'(active_r);
  assign in_oor    = 32'(in_chan.line) >= 32'(lines);
  assign in_fire   = in_chan.valid && in_chan.ready;
  assign su_fix    = (slots_used_r == '0) ? LCW'(1) : slots_used_r;
  assign room      = 32'(su_fix) < MAX_LINES;
  assign same_slot = map_rdata == above_r;
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || out_chan.ready);

  assign in_chan.ready       = (state_r == S_IDLE) && !map_busy;
  assign cfg_chan.ready      = 1'b1;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.colour_out = out_col_r;
  assign out_chan.slot       = out_slot_r;
  assign out_chan.split_made = out_split_r;
  assign out_chan.status     = out_status_r;

  always_comb begin
    map_cmd     = '0;
    map_addr    = ln_r;
    map_hi      = lines_r;
    map_wdata   = '0;
    pal_cmd     = '0;
    pal_rd_slot = '0;
    pal_rd_idx  = ci_r;
    pal_wr_slot = '0;
    pal_wr_idx  = ci_r;
    pal_wdata   = col_r;
    unique case (state_r)
      S_RST: begin
        map_cmd.fill = 1'b1;
        map_addr     = '0;
      end
      S_RD_A: begin
        map_cmd.rd = 1'b1;
      end
      S_RD_B: begin
        pal_cmd.rd  = 1'b1;
        pal_rd_slot = map_rdata;
      end
      S_WR0: begin
        pal_cmd.wr = 1'b1;
      end
      S_WA: begin
        map_cmd.rd = 1'b1;
        map_addr   = ln_r - SW'(1);
      end
      S_WB: begin
        map_cmd.rd = 1'b1;
      end
      S_WC: begin
        if (!same_slot || !room) begin
          pal_cmd.wr  = 1'b1;
          pal_wr_slot = map_rdata;
        end
      end
      S_CP: begin
        if (32'(k_r) < COLOURS_PER_PALETTE) begin
          pal_cmd.rd  = 1'b1;
          pal_rd_slot = above_r;
          pal_rd_idx  = IW'(k_r);
        end
        if (k_r != '0) begin
          pal_cmd.wr  = 1'b1;
          pal_wr_slot = fresh_r;
          pal_wr_idx  = IW'(k_r - KW'(1));
          pal_wdata   = pal_rdata;
        end
      end
      S_SPLIT: begin
        map_cmd.fill = 1'b1;
        map_wdata    = fresh_r;
        pal_cmd.wr   = 1'b1;
        pal_wr_slot  = fresh_r;
      end
      S_IDLE, S_RD_C, S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_r     <= plst_pkg::ACTIVE_RESET;
      slots_used_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        active_r <= cfg_chan.active_lines;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.valid && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            ln_r         <= SW'(in_chan.line);
            ci_r         <= ci_wrap(in_chan.colour_index);
            col_r        <= in_chan.colour_in;
            lines_r      <= lines;
            res_col_r    <= '0;
            res_slot_r   <= '0;
            res_split_r  <= 1'b0;
            unique case (in_chan.operation)
              plst_pkg::OP_RESET: begin
                res_status_r <= 1'b0;
                slots_used_r <= '0;
                state_r      <= S_RST;
              end
              plst_pkg::OP_WRITE: begin
                res_status_r <= in_oor;
                if (in_oor) begin
                  state_r <= S_FIN;
                end else if (in_chan.line == '0) begin
                  state_r <= S_WR0;
                end else begin
                  state_r <= S_WA;
                end
              end
              plst_pkg::OP_READ: begin
                res_status_r <= in_oor;
                if (in_oor) begin
                  state_r <= S_FIN;
                end else begin
                  state_r <= S_RD_A;
                end
              end
              default: begin
                res_status_r <= 1'b0;
                state_r      <= S_FIN;
              end
            endcase
          end
        end
        S_RST: begin
          state_r <= S_FIN;
        end
        S_RD_A: begin
          state_r <= S_RD_B;
        end
        S_RD_B: begin
          res_slot_r <= map_rdata;
          state_r    <= S_RD_C;
        end
        S_RD_C: begin
          res_col_r <= pal_rdata;
          state_r   <= S_FIN;
        end
        S_WR0: begin
          slots_used_r <= su_fix;
          res_col_r    <= col_r;
          state_r      <= S_FIN;
        end
        S_WA: begin
          state_r <= S_WB;
        end
        S_WB: begin
          above_r <= map_rdata;
          state_r <= S_WC;
        end
        S_WC: begin
          if (same_slot) begin
            slots_used_r <= su_fix;
          end
          if (!same_slot || !room) begin
            res_col_r  <= col_r;
            res_slot_r <= map_rdata;
            state_r    <= S_FIN;
          end else begin
            fresh_r <= SW'(su_fix);
            k_r     <= '0;
            state_r <= S_CP;
          end
        end
        S_CP: begin
          k_r <= k_r + KW'(1);
          if (32'(k_r) == COLOURS_PER_PALETTE) begin
            state_r <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          slots_used_r <= slots_used_r + LCW'(1);
          res_col_r    <= col_r;
          res_slot_r   <= fresh_r;
          res_split_r  <= 1'b1;
          state_r      <= S_FIN;
        end
        S_FIN: begin
          if (out_load) begin
            out_col_r    <= res_col_r;
            out_slot_r   <= plst_pkg::SLOT_W'(res_slot_r);
            out_split_r  <= res_split_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/plst_checker.sv]
// Port-level checks of the palette split table and their binding to the top level.
module plst_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [plst_pkg::COLOUR_W-1:0] colour_out,
  input logic [plst_pkg::SLOT_W-1:0]   slot,
  input logic                          split_made,
  input logic                          status
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("result or request side active right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while an item is in progress");

  a_ignored_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status |-> colour_out == '0 && slot == '0 && !split_made)
    else $error("ignored line carries data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(colour_out) && $stable(slot)
                                && $stable(split_made) && $stable(status))
    else $error("stalled result changed");

endmodule

bind per_line_palette_split_table plst_checker u_plst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .colour_out (out_chan.colour_out),
  .slot       (out_chan.slot),
  .split_made (out_chan.split_made),
  .status     (out_chan.status)
);
